>>> src/rpci_pkg.sv
// Shared types and constants for the RX power calibration interpolator.
// Used by every module in src; no dependencies of its own.
package rpci_pkg;

    localparam int W_NUM      = 48;      // dividend magnitude bits
    localparam int W_DEN      = 32;      // divisor magnitude bits
    localparam int DIV_STAGES = W_NUM;   // one quotient bit per stage
    localparam int N_LANES    = 3;

    localparam logic [19:0] RECIP10     = 20'd838861;  // ceil(2^23 / 10)
    localparam int          RECIP_SHIFT = 23;
    localparam logic [34:0] SAT_LIMIT   = 35'd655360;  // 10 * 65536
    localparam logic [15:0] PWR_MAX     = 16'hffff;
    localparam logic [3:0]  FIT_LAGRANGE = 4'd1;

    typedef enum logic [2:0] {
        CFG_RSSI_UP    = 3'd0,
        CFG_POWER_UP   = 3'd1,
        CFG_RSSI_MID   = 3'd2,
        CFG_POWER_MID  = 3'd3,
        CFG_RSSI_DOWN  = 3'd4,
        CFG_POWER_DOWN = 3'd5,
        CFG_FIT_MODE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] rssi_up;
        logic [15:0] power_up;
        logic [15:0] rssi_mid;
        logic [15:0] power_mid;
        logic [15:0] rssi_down;
        logic [15:0] power_down;
        logic        is_lag;
    } t_cal;

    typedef struct packed {
        logic [W_NUM-1:0] num;
        logic [W_DEN-1:0] den;
        logic             neg;
    } t_div_op;

    typedef struct packed {
        logic [W_NUM-1:0] quo;
        logic             neg;
    } t_div_res;

    typedef struct packed {
        logic        is_lag;
        logic [15:0] base;
    } t_side;

endpackage

>>> src/rpci_prep.sv
// Front stages: products of RSSI differences, numerators, sign/magnitude split.
// Depends on rpci_pkg.
module rpci_prep (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [15:0]                i_rssi,
    input  rpci_pkg::t_cal             i_cal,
    output logic                       o_valid,
    output rpci_pkg::t_div_op          o_op [rpci_pkg::N_LANES],
    output rpci_pkg::t_side            o_side
);

    // stage 1
    logic        r_s1_valid;
    logic [15:0] r_s1_r;
    logic        r_s1_lag;

    // stage 2
    logic               r_s2_valid;
    logic signed [33:0] r_s2_t [rpci_pkg::N_LANES];
    logic signed [33:0] r_s2_lp;
    logic signed [16:0] r_s2_lden;
    logic [15:0]        r_s2_base;
    logic               r_s2_lag;
    logic signed [33:0] n_s2_t [rpci_pkg::N_LANES];
    logic signed [33:0] n_s2_lp;
    logic signed [16:0] n_s2_lden;
    logic [15:0]        n_s2_base;

    // stage 3
    logic               r_s3_valid;
    logic signed [50:0] r_s3_n [rpci_pkg::N_LANES];
    logic signed [33:0] r_s3_lp;
    logic signed [16:0] r_s3_lden;
    logic [15:0]        r_s3_base;
    logic               r_s3_lag;

    // stage 4 (divider operands)
    logic                     r_s4_valid;
    rpci_pkg::t_div_op        r_s4_op [rpci_pkg::N_LANES];
    rpci_pkg::t_side          r_s4_side;
    rpci_pkg::t_div_op        n_s4_op [rpci_pkg::N_LANES];

    // Lagrange denominators follow the calibration registers
    logic signed [33:0] r_d [rpci_pkg::N_LANES];

    logic signed [16:0] c_r0, c_r1, c_r2, c_p0, c_p1, c_p2, c_rv;
    logic signed [16:0] c_la, c_lb;

    assign c_r0 = {1'b0, i_cal.rssi_down};
    assign c_r1 = {1'b0, i_cal.rssi_mid};
    assign c_r2 = {1'b0, i_cal.rssi_up};
    assign c_p0 = {1'b0, i_cal.power_down};
    assign c_p1 = {1'b0, i_cal.power_mid};
    assign c_p2 = {1'b0, i_cal.power_up};
    assign c_rv = {1'b0, r_s1_r};

    always_ff @(posedge i_clk) begin
        r_d[0] <= (c_r0 - c_r1) * (c_r0 - c_r2);
        r_d[1] <= (c_r1 - c_r0) * (c_r1 - c_r2);
        r_d[2] <= (c_r2 - c_r0) * (c_r2 - c_r1);
    end

    // stage 2: basis products and the linear segment product
    always_comb begin
        n_s2_t[0] = (c_rv - c_r1) * (c_rv - c_r2);
        n_s2_t[1] = (c_rv - c_r0) * (c_rv - c_r2);
        n_s2_t[2] = (c_rv - c_r0) * (c_rv - c_r1);
        if (r_s1_r <= i_cal.rssi_down) begin
            // through the origin; zero when the lower code is zero
            c_la      = (i_cal.rssi_down == 16'd0) ? 17'sd0 : c_rv;
            c_lb      = c_p0;
            n_s2_lden = (i_cal.rssi_down == 16'd0) ? 17'sd1 : c_r0;
            n_s2_base = 16'd0;
        end else if (r_s1_r < i_cal.rssi_mid) begin
            c_la      = c_rv - c_r0;
            c_lb      = c_p1 - c_p0;
            n_s2_lden = c_r1 - c_r0;
            n_s2_base = i_cal.power_down;
        end else begin
            c_la      = c_rv - c_r1;
            c_lb      = c_p2 - c_p1;
            n_s2_lden = (i_cal.rssi_up == i_cal.rssi_mid) ? 17'sd1 : (c_r2 - c_r1);
            n_s2_base = i_cal.power_mid;
        end
        n_s2_lp = c_la * c_lb;
    end

    // stage 4: sign/magnitude split; Lagrange skips zero-denominator terms
    always_comb begin
        logic [50:0] nabs;
        logic [33:0] dabs;
        logic [33:0] labs;
        logic [16:0] ldabs;
        for (int k = 0; k < rpci_pkg::N_LANES; k++) begin
            nabs = r_s3_n[k][50] ? 51'(-r_s3_n[k]) : 51'(r_s3_n[k]);
            dabs = r_d[k][33] ? 34'(-r_d[k]) : 34'(r_d[k]);
            if (r_s3_lag && r_d[k] != 34'sd0) begin
                n_s4_op[k].num = nabs[rpci_pkg::W_NUM-1:0];
                n_s4_op[k].den = dabs[rpci_pkg::W_DEN-1:0];
                n_s4_op[k].neg = r_s3_n[k][50] ^ r_d[k][33];
            end else begin
                n_s4_op[k].num = '0;
                n_s4_op[k].den = rpci_pkg::W_DEN'(1);
                n_s4_op[k].neg = 1'b0;
            end
        end
        labs  = r_s3_lp[33] ? 34'(-r_s3_lp) : 34'(r_s3_lp);
        ldabs = r_s3_lden[16] ? 17'(-r_s3_lden) : 17'(r_s3_lden);
        if (!r_s3_lag) begin
            n_s4_op[0].num = rpci_pkg::W_NUM'(labs);
            n_s4_op[0].den = rpci_pkg::W_DEN'(ldabs);
            n_s4_op[0].neg = r_s3_lp[33] ^ r_s3_lden[16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_r    <= i_rssi;
            r_s1_lag  <= i_cal.is_lag;
            r_s2_t    <= n_s2_t;
            r_s2_lp   <= n_s2_lp;
            r_s2_lden <= n_s2_lden;
            r_s2_base <= n_s2_base;
            r_s2_lag  <= r_s1_lag;
            r_s3_n[0] <= c_p0 * r_s2_t[0];
            r_s3_n[1] <= c_p1 * r_s2_t[1];
            r_s3_n[2] <= c_p2 * r_s2_t[2];
            r_s3_lp   <= r_s2_lp;
            r_s3_lden <= r_s2_lden;
            r_s3_base <= r_s2_base;
            r_s3_lag  <= r_s2_lag;
            r_s4_op   <= n_s4_op;
            r_s4_side.is_lag <= r_s3_lag;
            r_s4_side.base   <= r_s3_base;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_op    = r_s4_op;
    assign o_side  = r_s4_side;

endmodule

>>> src/rpci_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on rpci_pkg.
module rpci_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  rpci_pkg::t_div_op   i_op,
    input  rpci_pkg::t_side     i_side,
    output logic                o_valid,
    output rpci_pkg::t_div_res  o_res,
    output rpci_pkg::t_side     o_side
);

    localparam int LAST = rpci_pkg::DIV_STAGES - 1;

    logic                       r_vld  [rpci_pkg::DIV_STAGES];
    logic [rpci_pkg::W_DEN-1:0] r_rem  [rpci_pkg::DIV_STAGES];
    logic [rpci_pkg::W_NUM-1:0] r_nq   [rpci_pkg::DIV_STAGES];
    logic [rpci_pkg::W_DEN-1:0] r_den  [rpci_pkg::DIV_STAGES];
    logic                       r_neg  [rpci_pkg::DIV_STAGES];
    rpci_pkg::t_side            r_side [rpci_pkg::DIV_STAGES];

    for (genvar k = 0; k < rpci_pkg::DIV_STAGES; k++) begin : g_stage
        logic                       p_vld;
        logic [rpci_pkg::W_DEN-1:0] p_rem;
        logic [rpci_pkg::W_NUM-1:0] p_nq;
        logic [rpci_pkg::W_DEN-1:0] p_den;
        logic                       p_neg;
        rpci_pkg::t_side            p_side;
        logic [rpci_pkg::W_DEN:0]   c_trial;
        logic [rpci_pkg::W_DEN-1:0] n_rem;
        logic [rpci_pkg::W_NUM-1:0] n_nq;

        if (k == 0) begin : g_head
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_nq   = i_op.num;
            assign p_den  = i_op.den;
            assign p_neg  = i_op.neg;
            assign p_side = i_side;
        end else begin : g_body
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_nq   = r_nq[k-1];
            assign p_den  = r_den[k-1];
            assign p_neg  = r_neg[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            c_trial = {p_rem, p_nq[rpci_pkg::W_NUM-1]};
            if (c_trial >= {1'b0, p_den}) begin
                n_rem = rpci_pkg::W_DEN'(c_trial - {1'b0, p_den});
                n_nq  = {p_nq[rpci_pkg::W_NUM-2:0], 1'b1};
            end else begin
                n_rem = c_trial[rpci_pkg::W_DEN-1:0];
                n_nq  = {p_nq[rpci_pkg::W_NUM-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_nq[k]   <= n_nq;
                r_den[k]  <= p_den;
                r_neg[k]  <= p_neg;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid   = r_vld[LAST];
    assign o_res.quo = r_nq[LAST];
    assign o_res.neg = r_neg[LAST];
    assign o_side    = r_side[LAST];

endmodule

>>> src/rpci_post.sv
// Back stages: signed quotient sum, clamp, divide by ten.
// Depends on rpci_pkg.
module rpci_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  rpci_pkg::t_div_res  i_res [rpci_pkg::N_LANES],
    input  rpci_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [15:0]         o_word
);

    logic               r_s5_valid, r_s6_valid, r_s7_valid;
    logic signed [34:0] r_s5_v;
    logic signed [34:0] n_s5_v;
    logic [19:0]        r_s6_x;
    logic               r_s6_sat;
    logic [19:0]        n_s6_x;
    logic               n_s6_sat;
    logic [15:0]        r_s7_word;
    logic [39:0]        c_prod;

    always_comb begin
        logic signed [48:0] sq [rpci_pkg::N_LANES];
        logic [31:0]        s32;
        for (int k = 0; k < rpci_pkg::N_LANES; k++) begin
            sq[k] = i_res[k].neg ? -$signed({1'b0, i_res[k].quo})
                                 :  $signed({1'b0, i_res[k].quo});
        end
        // Lagrange sum wraps to 32 bits
        s32 = sq[0][31:0] + sq[1][31:0] + sq[2][31:0];
        if (i_side.is_lag) begin
            n_s5_v = {{3{s32[31]}}, s32};
        end else begin
            n_s5_v = $signed(sq[0][34:0]) + $signed({19'd0, i_side.base});
        end
    end

    always_comb begin
        n_s6_x   = r_s5_v[19:0];
        n_s6_sat = 1'b0;
        if (r_s5_v[34]) begin
            n_s6_x = '0;
        end else if (r_s5_v >= $signed(rpci_pkg::SAT_LIMIT)) begin
            n_s6_sat = 1'b1;
        end
    end

    assign c_prod = r_s6_x * rpci_pkg::RECIP10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else if (i_en) begin
            r_s5_valid <= i_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_v    <= n_s5_v;
            r_s6_x    <= n_s6_x;
            r_s6_sat  <= n_s6_sat;
            r_s7_word <= r_s6_sat ? rpci_pkg::PWR_MAX
                                  : c_prod[rpci_pkg::RECIP_SHIFT +: 16];
        end
    end

    assign o_valid = r_s7_valid;
    assign o_word  = r_s7_word;

endmodule

>>> src/rx_power_calibration_interpolator_core.sv
// Top level: calibration registers, pipeline, output register with skid.
// Depends on rpci_pkg, rpci_prep, rpci_div, rpci_post.
//
// Converts each RSSI sample to a clamped power word (0.1 uW units) using three
// calibration points, either as a quadratic Lagrange fit (fit_mode 1) or as
// three-segment linear interpolation. One sample is taken every cycle while
// o_stall is low; each result passes through the prep stages, the 48-stage
// divider lanes (one quotient bit per stage), the post stages and the output
// register. Lagrange denominators are recomputed from the calibration
// registers in the cycle after a write. o_stall rises only while the skid
// register holds a result behind a stalled output.
module rx_power_calibration_interpolator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_rssi_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_rx_power_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    rpci_pkg::t_cal     r_cal;
    logic [3:0]         r_fit_mode;
    rpci_pkg::t_cal     c_cal;

    logic               c_en;
    logic               prep_valid;
    rpci_pkg::t_div_op  prep_op [rpci_pkg::N_LANES];
    rpci_pkg::t_side    prep_side;
    logic               div_valid [rpci_pkg::N_LANES];
    rpci_pkg::t_div_res div_res [rpci_pkg::N_LANES];
    rpci_pkg::t_side    div_side [rpci_pkg::N_LANES];
    logic               pipe_valid;
    logic [15:0]        pipe_word;

    logic               r_out_valid;
    logic [15:0]        r_out_word;
    logic               r_skid_valid;
    logic [15:0]        r_skid_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal      <= '0;
            r_fit_mode <= '0;
        end else if (i_cfg_valid) begin
            case (rpci_pkg::t_cfg_idx'(i_cfg_index))
                rpci_pkg::CFG_RSSI_UP:    r_cal.rssi_up    <= i_cfg_data;
                rpci_pkg::CFG_POWER_UP:   r_cal.power_up   <= i_cfg_data;
                rpci_pkg::CFG_RSSI_MID:   r_cal.rssi_mid   <= i_cfg_data;
                rpci_pkg::CFG_POWER_MID:  r_cal.power_mid  <= i_cfg_data;
                rpci_pkg::CFG_RSSI_DOWN:  r_cal.rssi_down  <= i_cfg_data;
                rpci_pkg::CFG_POWER_DOWN: r_cal.power_down <= i_cfg_data;
                rpci_pkg::CFG_FIT_MODE:   r_fit_mode       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        c_cal        = r_cal;
        c_cal.is_lag = (r_fit_mode == rpci_pkg::FIT_LAGRANGE);
    end

    // advance the whole pipeline unless the skid register is occupied
    assign c_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    rpci_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_rssi  (i_rssi_sample),
        .i_cal   (c_cal),
        .o_valid (prep_valid),
        .o_op    (prep_op),
        .o_side  (prep_side)
    );

    for (genvar k = 0; k < rpci_pkg::N_LANES; k++) begin : g_lane
        rpci_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (c_en),
            .i_valid (prep_valid),
            .i_op    (prep_op[k]),
            .i_side  (prep_side),
            .o_valid (div_valid[k]),
            .o_res   (div_res[k]),
            .o_side  (div_side[k])
        );
    end

    rpci_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (div_valid[0]),
        .i_res   (div_res),
        .i_side  (div_side[0]),
        .o_valid (pipe_valid),
        .o_word  (pipe_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= pipe_valid;
            end
        end else if (pipe_valid && c_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_word <= r_skid_valid ? r_skid_word : pipe_word;
        end else if (pipe_valid && c_en) begin
            r_skid_word <= pipe_word;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_rx_power_word = r_out_word;

    // a held skid transaction always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full with output empty");

    // divider lanes move in lockstep
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_valid[0] == div_valid[1]) && (div_valid[0] == div_valid[2]))
        else $error("divider lane valid bits diverged");

    // skid stays occupied while the output is stalled
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> r_skid_valid)
        else $error("skid transaction dropped under stall");

endmodule

>>> tb/rx_power_calibration_interpolator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rx_power_calibration_interpolator_core.
// Depends on rpci_pkg and the core; holds its own power-word predictor and result checker.
module rx_power_calibration_interpolator_core_tb;

    localparam int          LATENCY_WAIT = 100;
    localparam int          WATCHDOG_MAX = 5000;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;
    localparam logic [3:0]  FIT_LINEAR   = 4'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_rssi_sample;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_rx_power_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    rx_power_calibration_interpolator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rssi_sample  (i_rssi_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rx_power_word(o_rx_power_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // calibration copy
    logic [15:0] cal_rssi_up, cal_power_up, cal_rssi_mid, cal_power_mid;
    logic [15:0] cal_rssi_down, cal_power_down;
    logic [3:0]  cal_fit_mode;

    logic [15:0] expected_power_q[$];
    int          error_count;
    int          samples_sent;
    int          words_checked;
    int          idle_cycles;
    int          burst_left;
    bit          gaps_enabled;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [15:0] predict_power(logic [15:0] sample);
        longint r, r0, r1, r2, p0, p1, p2, d0, d1, d2, acc, pwr, span;
        logic [31:0] low;
        r  = sample;
        r0 = cal_rssi_down; p0 = cal_power_down;
        r1 = cal_rssi_mid;  p1 = cal_power_mid;
        r2 = cal_rssi_up;   p2 = cal_power_up;
        if (cal_fit_mode == rpci_pkg::FIT_LAGRANGE) begin
            d0 = (r0 - r1) * (r0 - r2);
            d1 = (r1 - r0) * (r1 - r2);
            d2 = (r2 - r0) * (r2 - r1);
            acc = 0;
            if (d0 != 0) acc += p0 * (r - r1) * (r - r2) / d0;
            if (d1 != 0) acc += p1 * (r - r0) * (r - r2) / d1;
            if (d2 != 0) acc += p2 * (r - r0) * (r - r1) / d2;
            // keep the low word and read it as signed
            low = acc[31:0];
            pwr = longint'($signed(low));
        end else if (r <= r0) begin
            pwr = (r0 != 0) ? (r * p0) / r0 : 0;
        end else if (r < r1) begin
            pwr = p0 + (r - r0) * (p1 - p0) / (r1 - r0);
        end else begin
            span = r2 - r1;
            if (span == 0) span = 1;
            pwr = p1 + (r - r1) * (p2 - p1) / span;
        end
        pwr = pwr / 10;
        if (pwr < 0) pwr = 0;
        if (pwr > 65535) pwr = 65535;
        return pwr[15:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_power_q.size() == 0) begin
                report_mismatch($sformatf("unexpected power word %0d", o_rx_power_word));
            end else begin
                if (o_rx_power_word !== expected_power_q[0])
                    report_mismatch($sformatf("power word %0d, expected %0d",
                                              o_rx_power_word, expected_power_q[0]));
                void'(expected_power_q.pop_front());
                words_checked++;
            end
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    initial begin
        int mode, left, hold;
        i_stall <= 1'b0;
        mode = 0; left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(64, 256);
            end
            left--;
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 7) == 0);
                default: i_stall <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] sample);
        int gap;
        i_valid       <= 1'b1;
        i_rssi_sample <= sample;
        do @(posedge i_clk); while (o_stall);
        expected_power_q.push_back(predict_power(sample));
        samples_sent++;
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap = $urandom_range(1, 12);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        end_burst();
        while (expected_power_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] index, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        // drop valid for one cycle between writes
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (index)
            rpci_pkg::CFG_RSSI_UP:    cal_rssi_up    = data;
            rpci_pkg::CFG_POWER_UP:   cal_power_up   = data;
            rpci_pkg::CFG_RSSI_MID:   cal_rssi_mid   = data;
            rpci_pkg::CFG_POWER_MID:  cal_power_mid  = data;
            rpci_pkg::CFG_RSSI_DOWN:  cal_rssi_down  = data;
            rpci_pkg::CFG_POWER_DOWN: cal_power_down = data;
            rpci_pkg::CFG_FIT_MODE:   cal_fit_mode   = data[3:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(logic [15:0] rd, logic [15:0] pd, logic [15:0] rm,
                                    logic [15:0] pm, logic [15:0] ru, logic [15:0] pu,
                                    logic [15:0] mode_word);
        wait_drained();
        write_cfg(rpci_pkg::CFG_RSSI_DOWN, rd);
        write_cfg(rpci_pkg::CFG_POWER_DOWN, pd);
        write_cfg(rpci_pkg::CFG_RSSI_MID, rm);
        write_cfg(rpci_pkg::CFG_POWER_MID, pm);
        write_cfg(rpci_pkg::CFG_RSSI_UP, ru);
        write_cfg(rpci_pkg::CFG_POWER_UP, pu);
        write_cfg(rpci_pkg::CFG_FIT_MODE, mode_word);
        // let the denominators settle
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_point(logic [15:0] p);
        int v;
        v = int'(p) + int'($urandom_range(0, 8)) - 4;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 4))
            0: return near_point(cal_rssi_down);
            1: return near_point(cal_rssi_mid);
            2: return near_point(cal_rssi_up);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h5a5a);
    endtask

    task automatic test_linear_segments();
        load_calibration(16'd1000, 16'd5000, 16'd20000, 16'd40000, 16'd40000,
                         16'd65535, {12'd0, FIT_LINEAR});
        send_sample(16'd0);
        send_sample(16'd999);
        send_sample(16'd1000);
        send_sample(16'd1001);
        send_sample(16'd19999);
        send_sample(16'd20000);
        send_sample(16'd20001);
        send_sample(16'hffff);
        // equal up and mid: unit span, and a falling slope that reaches zero
        load_calibration(16'd100, 16'd65535, 16'd200, 16'd30000, 16'd200, 16'd0, 16'd15);
        send_sample(16'd200);
        send_sample(16'd201);
        send_sample(16'd50);
        // ignored register index
        wait_drained();
        write_cfg(CFG_UNUSED, 16'hffff);
        send_sample(16'd300);
    endtask

    task automatic test_lagrange_fit();
        load_calibration(16'd1000, 16'd100, 16'd30000, 16'd30000, 16'd60000,
                         16'd65535, {12'd0, rpci_pkg::FIT_LAGRANGE});
        send_sample(16'd0);
        send_sample(16'd1000);
        send_sample(16'd30000);
        send_sample(16'hffff);
        // coincident points drop terms with a zero denominator
        load_calibration(16'd5000, 16'd65535, 16'd5000, 16'd10, 16'd60000, 16'd20000,
                         {12'd0, rpci_pkg::FIT_LAGRANGE});
        send_sample(16'd0);
        send_sample(16'd40000);
        // tight spacing wraps the sum past 32 bits
        load_calibration(16'd0, 16'd65535, 16'd1, 16'd0, 16'd2, 16'd65535,
                         {12'd0, rpci_pkg::FIT_LAGRANGE});
        send_sample(16'hffff);
        send_sample(16'h8000);
    endtask

    task automatic test_random_calibrations();
        int phase, n;
        logic [15:0] a, b, c;
        for (phase = 0; phase < 8; phase++) begin
            a = 16'($urandom_range(0, 65535));
            b = 16'($urandom_range(0, 65535));
            c = 16'($urandom_range(0, 65535));
            if (phase == 0) begin
                load_calibration(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                 16'hffff, 16'hffff);
            end else if (phase % 3 != 0) begin
                // ordered points
                if (a > b) {a, b} = {b, a};
                if (b > c) {b, c} = {c, b};
                if (a > b) {a, b} = {b, a};
                load_calibration(a, 16'($urandom_range(0, 65535)), b,
                                 16'($urandom_range(0, 65535)),
                                 c, 16'($urandom_range(0, 65535)),
                                 (phase % 2) ? {12'd0, rpci_pkg::FIT_LAGRANGE}
                                             : 16'($urandom_range(0, 15)));
            end else begin
                load_calibration(a, 16'($urandom_range(0, 65535)), b,
                                 16'($urandom_range(0, 65535)),
                                 c, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
            end
            gaps_enabled = (phase % 4 != 3);
            for (n = 0; n < 40; n++) send_sample(pick_sample());
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int n;
        wait_drained();
        hold_request = 1'b1;
        gaps_enabled = 1'b0;
        for (n = 0; n < 100; n++) send_sample(pick_sample());
        gaps_enabled = 1'b1;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_rssi_sample <= 16'd0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= 3'd0;
        i_cfg_data    <= 16'd0;
        {cal_rssi_up, cal_power_up, cal_rssi_mid, cal_power_mid} = '0;
        {cal_rssi_down, cal_power_down} = '0;
        cal_fit_mode  = 4'd0;
        error_count   = 0;
        samples_sent  = 0;
        words_checked = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        gaps_enabled  = 1'b1;
        hold_request  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_linear_segments();
        test_lagrange_fit();
        test_random_calibrations();
        test_output_backpressure();
        wait_drained();

        $display("Covered reset defaults, linear segments, Lagrange fit, random calibrations");
        $display("and a long output hold-off: %0d samples sent, %0d words checked",
                 samples_sent, words_checked);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/rpci_pkg.sv
src/rpci_prep.sv
src/rpci_div.sv
src/rpci_post.sv
src/rx_power_calibration_interpolator_core.sv
tb/rx_power_calibration_interpolator_core_tb.sv
